// ----- rtl/csvfs_pkg.sv -----
package csvfs_pkg;

	localparam int MAX_FIELDS     = 256;
	localparam int FIELD_CNT_W    = $clog2(MAX_FIELDS + 1);
	localparam int ROW_INDEX_BITS = 20;

	// widths of the result fields as they leave the block
	localparam int CHAR_W     = 8;
	localparam int FIDX_W     = 8;
	localparam int RIDX_W     = 20;
	localparam int RFIELDS_W  = 9;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_DATA_W = CHAR_W + FIDX_W + RIDX_W + 2 * RFIELDS_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	localparam logic [7:0] QUOTE_BYTE   = 8'd34;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] DEFAULT_SEP  = 8'd44;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_QUOTE_SEEN
	} mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0]    out_char;
		logic                 char_valid;
		logic                 field_done;
		logic                 row_done;
		logic [FIDX_W-1:0]    field_index;
		logic [RIDX_W-1:0]    row_index;
		logic [RFIELDS_W-1:0] row_fields;
		logic [RFIELDS_W-1:0] max_columns;
	} res_t;

	function automatic logic [FIELD_CNT_W-1:0] sat_inc(input logic [FIELD_CNT_W-1:0] v);
		if (v >= FIELD_CNT_W'(MAX_FIELDS))
			return FIELD_CNT_W'(MAX_FIELDS);
		return v + FIELD_CNT_W'(1);
	endfunction

endpackage

// ----- rtl/csvfs_parser.sv -----
module csvfs_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_eos,
	input  logic                res_free,
	output logic                res_load,
	output csvfs_pkg::res_t     res
);

	logic                                  valid_s1;
	logic [7:0]                            byte_s1;
	logic                                  eos_s1;
	logic [7:0]                            sep_q;
	csvfs_pkg::mode_t                      mode_q, mode_d;
	logic                                  started_q, started_d;
	logic [csvfs_pkg::FIELD_CNT_W-1:0]     fcount_q, fcount_d, fc_one, fc_two;
	logic [csvfs_pkg::ROW_INDEX_BITS-1:0]  rcount_q, rcount_d;
	logic [csvfs_pkg::RFIELDS_W-1:0]       widest_q, widest_d;
	logic                                  advance;
	logic                                  emit, cvalid, fdone, rdone;
	logic [1:0]                            closes;
	logic [csvfs_pkg::RFIELDS_W-1:0]       rowf;

	assign advance  = valid_s1 && res_free;
	assign in_ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eos_s1  <= in_eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= csvfs_pkg::DEFAULT_SEP;
		end else if (cfg_valid) begin
			sep_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= csvfs_pkg::MODE_START;
			started_q <= 1'b0;
			fcount_q  <= '0;
			rcount_q  <= '0;
			widest_q  <= '0;
		end else if (advance) begin
			mode_q    <= mode_d;
			started_q <= started_d;
			fcount_q  <= fcount_d;
			rcount_q  <= rcount_d;
			widest_q  <= widest_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		started_d = started_q;
		cvalid    = 1'b0;
		fdone     = 1'b0;
		rdone     = 1'b0;
		emit      = 1'b0;
		closes    = 2'd0;
		if (byte_s1 == csvfs_pkg::NEWLINE_BYTE) begin
			emit  = 1'b1;
			rdone = 1'b1;
			if (started_q) begin
				fdone  = 1'b1;
				closes = 2'd1;
			end
		end else begin
			started_d = 1'b1;
			case (mode_q)
				csvfs_pkg::MODE_START: begin
					if (byte_s1 == csvfs_pkg::QUOTE_BYTE) begin
						mode_d = csvfs_pkg::MODE_QUOTED;
					end else if (byte_s1 == sep_q) begin
						fdone  = 1'b1;
						closes = 2'd1;
					end else begin
						cvalid = 1'b1;
						mode_d = csvfs_pkg::MODE_PLAIN;
					end
				end
				csvfs_pkg::MODE_PLAIN: begin
					if (byte_s1 == sep_q) begin
						fdone  = 1'b1;
						closes = 2'd1;
						mode_d = csvfs_pkg::MODE_START;
					end else begin
						cvalid = 1'b1;
					end
				end
				csvfs_pkg::MODE_QUOTED: begin
					if (byte_s1 == csvfs_pkg::QUOTE_BYTE)
						mode_d = csvfs_pkg::MODE_QUOTE_SEEN;
					else
						cvalid = 1'b1;
				end
				default: begin
					if (byte_s1 == csvfs_pkg::QUOTE_BYTE) begin
						cvalid = 1'b1;
						mode_d = csvfs_pkg::MODE_QUOTED;
					end else if (byte_s1 == sep_q) begin
						fdone  = 1'b1;
						closes = 2'd1;
						mode_d = csvfs_pkg::MODE_START;
					end else begin
						cvalid = 1'b1;
						mode_d = csvfs_pkg::MODE_PLAIN;
					end
				end
			endcase
			emit = cvalid || fdone;
			if (eos_s1) begin
				emit   = 1'b1;
				fdone  = 1'b1;
				rdone  = 1'b1;
				closes = closes + 2'd1;
			end
		end

		// a final separator closes two fields in one go
		fc_one = (closes != 2'd0) ? csvfs_pkg::sat_inc(fcount_q) : fcount_q;
		fc_two = (closes == 2'd2) ? csvfs_pkg::sat_inc(fc_one) : fc_one;

		fcount_d = fc_two;
		rcount_d = rcount_q;
		widest_d = widest_q;
		rowf     = '0;
		if (rdone) begin
			rowf     = csvfs_pkg::RFIELDS_W'(fc_two);
			if (rowf > widest_q)
				widest_d = rowf;
			if (rcount_q != '1)
				rcount_d = rcount_q + csvfs_pkg::ROW_INDEX_BITS'(1);
			fcount_d  = '0;
			started_d = 1'b0;
			mode_d    = csvfs_pkg::MODE_START;
		end
	end

	assign res_load = advance && emit;

	always_comb begin
		res.out_char    = cvalid ? byte_s1 : '0;
		res.char_valid  = cvalid;
		res.field_done  = fdone;
		res.row_done    = rdone;
		res.field_index = (fcount_q > csvfs_pkg::FIELD_CNT_W'(csvfs_pkg::MAX_FIELDS - 1))
			? csvfs_pkg::FIDX_W'(csvfs_pkg::MAX_FIELDS - 1)
			: csvfs_pkg::FIDX_W'(fcount_q);
		res.row_index   = csvfs_pkg::RIDX_W'(rcount_q);
		res.row_fields  = rowf;
		res.max_columns = widest_d;
	end

`ifndef SYNTHESIS
	a_fcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= csvfs_pkg::FIELD_CNT_W'(csvfs_pkg::MAX_FIELDS))
		else $error("field count beyond limit");

	a_row_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.row_done) |=>
		(fcount_q == '0 && !started_q && mode_q == csvfs_pkg::MODE_START))
		else $error("row end left parse state behind");

	a_widest: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.row_done) |-> (res.row_fields <= res.max_columns))
		else $error("row wider than recorded maximum");

	a_silent_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !emit) |=> $stable(fcount_q) && $stable(rcount_q))
		else $error("silent byte changed counts");
`endif

endmodule

// ----- rtl/csvfs_out_reg.sv -----
module csvfs_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_load,
	input  csvfs_pkg::res_t  res,
	output logic             res_free,
	output logic             out_valid,
	input  logic             out_ready,
	output csvfs_pkg::res_t  out_res
);

	logic            valid_q;
	csvfs_pkg::res_t res_q;

	assign res_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_load)
			res_q <= res;
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> valid_q && $stable(res_q))
		else $error("pending result overwritten");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_q && !res_load) |=> !valid_q)
		else $error("result appeared without a load");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(res_free && res_load) |=> valid_q)
		else $error("loaded result not presented");
`endif

endmodule

// ----- rtl/csv_field_splitter.sv -----
// csv field splitter: turns a byte stream of csv text into field content bytes
// with field and row boundaries, one byte per transfer on the slave side.
// slave side: s_tdata[7:0] is the text byte, s_tlast marks the final byte of
// the stream and closes any open line after it.
// master side: one result per byte that carries content or ends a field or
// row; opening quotes and possible closing quotes give no result.
// cfg_valid/cfg_data write the separator byte (comma after reset); cfg_ready
// is always high and writes are expected only while the block is idle.
// an accepted byte waits in the input register; its result is loaded into the
// output register as the byte leaves the input register, once that register
// is free. throughput is one byte per cycle while the master side is not
// stalled, set by the parse state registers that update as a byte leaves the
// input register.
// a stalled master side holds its result; the input register then fills and
// s_tready falls until the result is taken.
// reset clears the parse state, counts and separator and empties both
// registers; no clearing pass is needed.
module csv_field_splitter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [7:0]                          cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [csvfs_pkg::IN_TDATA_W-1:0]    s_tdata,  // in_byte
	input  logic                                s_tlast,  // end_of_stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_char, field_index, row_index, row_fields, max_columns, zero fill
	output logic [csvfs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic [csvfs_pkg::OUT_TUSER_W-1:0]   m_tuser,  // char_valid, field_done
	output logic                                m_tlast   // row_done
);

	logic            res_free;
	logic            res_load;
	csvfs_pkg::res_t res;
	csvfs_pkg::res_t out_res;

	assign cfg_ready = 1'b1;

	csvfs_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_eos   (s_tlast),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	csvfs_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res      (res),
		.res_free (res_free),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = csvfs_pkg::OUT_TDATA_W'({out_res.max_columns, out_res.row_fields,
		out_res.row_index, out_res.field_index, out_res.out_char});
	assign m_tuser = {out_res.field_done, out_res.char_valid};
	assign m_tlast = out_res.row_done;

endmodule

// ----- sim/tb_csv_field_splitter.sv -----
`timescale 1ns / 1ps

module tb_csv_field_splitter;
	import csvfs_pkg::*;

	localparam int FIDX_LO  = CHAR_W;
	localparam int RIDX_LO  = FIDX_LO + FIDX_W;
	localparam int RF_LO    = RIDX_LO + RIDX_W;
	localparam int MC_LO    = RF_LO + RFIELDS_W;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 1000;

	typedef struct {
		logic [7:0] text_byte;
		logic       stream_end;
	} text_item_t;

	class field_split_board;
		logic [7:0]             separator;
		mode_t                  mode;
		bit                     line_started;
		logic [FIELD_CNT_W-1:0] field_count;
		logic [RIDX_W-1:0]      row_count;
		logic [RFIELDS_W-1:0]   widest_row;
		res_t                   awaited[$];
		int                     mismatches;

		function new();
			separator    = DEFAULT_SEP;
			mode         = MODE_START;
			line_started = 0;
			field_count  = '0;
			row_count    = '0;
			widest_row   = '0;
			mismatches   = 0;
		endfunction

		task report_mismatch(string what);
			$display("%0t mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		// works out the result, if any, of one accepted byte
		function void note_byte(logic [7:0] b, logic eos);
			res_t r;
			bit   emit, cv, fd, rd;
			int   closes;
			r = '0;
			emit = 0; cv = 0; fd = 0; rd = 0;
			closes = 0;
			r.field_index = (field_count > FIELD_CNT_W'(MAX_FIELDS - 1)) ?
				FIDX_W'(MAX_FIELDS - 1) : field_count[FIDX_W-1:0];
			r.row_index = row_count;
			if (b == NEWLINE_BYTE) begin
				emit = 1;
				rd = 1;
				if (line_started) begin
					fd = 1;
					closes = 1;
				end
			end else begin
				line_started = 1;
				case (mode)
					MODE_START: begin
						if (b == QUOTE_BYTE) begin
							mode = MODE_QUOTED;
						end else if (b == separator) begin
							fd = 1;
							closes = 1;
						end else begin
							cv = 1;
							mode = MODE_PLAIN;
						end
					end
					MODE_PLAIN: begin
						if (b == separator) begin
							fd = 1;
							closes = 1;
							mode = MODE_START;
						end else begin
							cv = 1;
						end
					end
					MODE_QUOTED: begin
						if (b == QUOTE_BYTE)
							mode = MODE_QUOTE_SEEN;
						else
							cv = 1;
					end
					default: begin
						// a second quote is literal, a separator ends the field, anything else is copied verbatim
						if (b == QUOTE_BYTE) begin
							cv = 1;
							mode = MODE_QUOTED;
						end else if (b == separator) begin
							fd = 1;
							closes = 1;
							mode = MODE_START;
						end else begin
							cv = 1;
							mode = MODE_PLAIN;
						end
					end
				endcase
				if (cv || fd)
					emit = 1;
				if (eos) begin
					emit = 1;
					fd = 1;
					rd = 1;
					closes++;
				end
			end
			repeat (closes)
				if (field_count < FIELD_CNT_W'(MAX_FIELDS))
					field_count++;
			if (rd) begin
				r.row_fields = field_count;
				if (field_count > widest_row)
					widest_row = field_count;
				if (row_count != '1)
					row_count++;
				field_count = '0;
				line_started = 0;
				mode = MODE_START;
			end
			if (emit) begin
				r.out_char    = cv ? b : 8'd0;
				r.char_valid  = cv;
				r.field_done  = fd;
				r.row_done    = rd;
				r.max_columns = widest_row;
				awaited = {awaited, r};
			end
		endfunction

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_split(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] flags,
		                 logic row_end);
			res_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result, tdata %h", data));
				return;
			end
			want = awaited.pop_front();
			compare_field("out_char", 32'(data[CHAR_W-1:0]), 32'(want.out_char));
			compare_field("field_index", 32'(data[FIDX_LO +: FIDX_W]),
				32'(want.field_index));
			compare_field("row_index", 32'(data[RIDX_LO +: RIDX_W]), 32'(want.row_index));
			compare_field("row_fields", 32'(data[RF_LO +: RFIELDS_W]),
				32'(want.row_fields));
			compare_field("max_columns", 32'(data[MC_LO +: RFIELDS_W]),
				32'(want.max_columns));
			compare_field("zero fill", 32'(data >> OUT_DATA_W), 32'd0);
			compare_field("char_valid", 32'(flags[0]), 32'(want.char_valid));
			compare_field("field_done", 32'(flags[1]), 32'(want.field_done));
			compare_field("row_done", 32'(row_end), 32'(want.row_done));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [7:0]             cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // in_byte
	logic                   s_tlast;   // end_of_stream
	logic                   m_tvalid;
	logic                   m_tready;
	// out_char, field_index, row_index, row_fields, max_columns, zero fill
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;   // char_valid, field_done
	logic                   m_tlast;   // row_done

	field_split_board board;
	text_item_t       text_q[$];
	bit               quiet;
	logic [7:0]       phase_seps [6] = '{8'd9, 8'd0, 8'd255, NEWLINE_BYTE, QUOTE_BYTE,
	                                     DEFAULT_SEP};

	csv_field_splitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void push_byte(logic [7:0] b, logic eos);
		text_item_t it;
		it.text_byte = b;
		it.stream_end = eos;
		text_q = {text_q, it};
	endfunction

	// random byte that is neither newline nor separator, and no quote unless allowed
	function automatic logic [7:0] pick_byte(logic [7:0] sep, bit allow_quote);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == NEWLINE_BYTE || b == sep || (!allow_quote && b == QUOTE_BYTE));
		return b;
	endfunction

	function automatic void add_directed();
		push_byte(NEWLINE_BYTE, 0);                 // empty line
		push_byte("a", 0);                          // trailing separator
		push_byte(DEFAULT_SEP, 0);
		push_byte(NEWLINE_BYTE, 0);
		push_byte(QUOTE_BYTE, 0);                   // quoted separator, doubled quote, tail
		push_byte(DEFAULT_SEP, 0);
		push_byte(QUOTE_BYTE, 0);
		push_byte(QUOTE_BYTE, 0);
		push_byte(QUOTE_BYTE, 0);
		push_byte("z", 0);
		push_byte(8'h00, 0);
		push_byte(DEFAULT_SEP, 0);
		push_byte(QUOTE_BYTE, 0);                   // unclosed quote
		push_byte(8'hff, 0);
		push_byte(NEWLINE_BYTE, 0);
		push_byte(8'hff, 0);                        // separator as final byte
		push_byte(DEFAULT_SEP, 1);
		push_byte("q", 0);                          // newline as final byte
		push_byte(NEWLINE_BYTE, 1);
		push_byte(QUOTE_BYTE, 1);                   // opening quote as final byte
		push_byte(QUOTE_BYTE, 0);                   // possible closing quote as final byte
		push_byte("a", 0);
		push_byte(QUOTE_BYTE, 1);
	endfunction

	function automatic void add_row(logic [7:0] sep);
		int n, len, start;
		start = text_q.size();
		n = $urandom_range(0, 6);
		for (int f = 0; f < n; f++) begin
			if (f > 0)
				push_byte(sep, 0);
			case ($urandom_range(0, 2))
				0: ;
				1: begin
					len = $urandom_range(1, 5);
					for (int i = 0; i < len; i++)
						push_byte(pick_byte(sep, i > 0), 0);
				end
				default: begin
					push_byte(QUOTE_BYTE, 0);
					len = $urandom_range(0, 5);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 5) == 0) begin
							push_byte(QUOTE_BYTE, 0);
							push_byte(QUOTE_BYTE, 0);
						end else begin
							push_byte(pick_byte(QUOTE_BYTE, 0), 0);
						end
					end
					push_byte(QUOTE_BYTE, 0);
					if ($urandom_range(0, 2) == 0) begin
						len = $urandom_range(1, 3);
						repeat (len)
							push_byte(pick_byte(sep, 0), 0);
					end
				end
			endcase
		end
		case ($urandom_range(0, 9))
			7: begin
				push_byte(sep, 0);
				push_byte(NEWLINE_BYTE, 0);
			end
			8: begin
				if (text_q.size() > start)
					text_q[$].stream_end = 1;
				else
					push_byte(NEWLINE_BYTE, 0);
			end
			9: push_byte(NEWLINE_BYTE, 1);
			default: push_byte(NEWLINE_BYTE, 0);
		endcase
	endfunction

	function automatic void add_noise(logic [7:0] sep);
		int len;
		logic [7:0] b;
		len = $urandom_range(1, 10);
		repeat (len) begin
			case ($urandom_range(0, 7))
				0: b = sep;
				1: b = QUOTE_BYTE;
				2: b = NEWLINE_BYTE;
				default: b = 8'($urandom_range(0, 255));
			endcase
			push_byte(b, $urandom_range(0, 15) == 0);
		end
	endfunction

	function automatic void add_random_text(logic [7:0] sep, int target);
		int first;
		first = text_q.size();
		while (text_q.size() - first < target) begin
			if ($urandom_range(0, 6) == 0)
				add_noise(sep);
			else
				add_row(sep);
		end
	endfunction

	task send_text();
		text_item_t it;
		int gap;
		while (text_q.size() > 0) begin
			it = text_q.pop_front();
			if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 15);
				@(negedge clk);
				s_tvalid <= 0;
				repeat (gap - 1)
					@(negedge clk);
			end
			@(negedge clk);
			s_tvalid <= 1;
			s_tdata  <= it.text_byte;
			s_tlast  <= it.stream_end;
			do
				@(posedge clk);
			while (!s_tready);
			board.note_byte(it.text_byte, it.stream_end);
		end
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	task write_separator(logic [7:0] sep);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data  <= sep;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.separator = sep;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// silent bytes may still sit inside the block once the last result is out
	task wait_settled();
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// result side back-pressure in bursts
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !quiet) begin
				m_tready <= 0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				m_tready <= 0;
				stall_left = $urandom_range(1, 15) - 1;
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_split(m_tdata, m_tuser, m_tlast);

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		board = new();
		quiet = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		add_directed();
		send_text();
		wait_settled();

		foreach (phase_seps[p]) begin
			write_separator(phase_seps[p]);
			// last setting runs with both sides flat out
			if (p == 5)
				quiet = 1;
			add_random_text(phase_seps[p], 65);
			// one very wide row drives the field counts into saturation
			if (p == 2) begin
				repeat (270)
					push_byte(phase_seps[p], 0);
				push_byte(NEWLINE_BYTE, 0);
			end
			send_text();
			wait_settled();
		end

		if (board.awaited.size() != 0)
			board.report_mismatch("results never arrived");
		if (board.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/csvfs_pkg.sv
rtl/csvfs_parser.sv
rtl/csvfs_out_reg.sv
rtl/csv_field_splitter.sv
sim/tb_csv_field_splitter.sv
